/* hw/rtl/dsrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrb_pkg: shared types and constants of the decimating sample ring buffer
// ring geometry, operation codes, mode codes, register indexes, sequencer states
// ----------------------------------------------------------------------------
package dsrb_pkg;

  // ring geometry
  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SIZE_W     = $clog2(RING_DEPTH + 1);

  // field widths
  localparam int SMP_W  = 32;
  localparam int ACC_W  = 48;
  localparam int RAT_W  = 16;
  localparam int MODE_W = 3;
  localparam int DCNT_W = $clog2(ACC_W);

  // stream and config port widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // operation carried in the input tuser
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // reduction modes; every code at or above MODE_AVG averages
  localparam logic [MODE_W-1:0] MODE_CIRC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVG  = 3'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ
  } state_t;

endpackage

/* hw/rtl/decimating_sample_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_sample_ring_buffer_unit: n-to-1 decimator feeding a sample ring
// reduces groups of signed q16.16 samples to min, max or average and keeps
// the results in a ring that can be read back oldest first
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+--------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata sample, read_pos
//            |           |                                | tuser op
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata stored_value,
//            |           |                                | read_data, used_count,
//            |           |                                | write_pos; tuser stored
//  cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// push without group end, min/max group end, clear and circular store answer
// in the cycle after the word is accepted; a read passes the registered ring ram
// port and then the output register; a push that ends an averaging group first
// runs the 1-bit-per-cycle restoring divider (48 dividend bits) of the average mode.
// one word is in flight at a time: s_axis_tready is high only when the
// sequencer is idle and the output register is empty.
// rst is synchronous; it clears offsets, fill count, phase, accumulator and
// the registers; ring contents are undefined until written.
// ----------------------------------------------------------------------------
module decimating_sample_ring_buffer_unit (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dsrb_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample[31:0], read_pos[41:32]
  input  logic [dsrb_pkg::IN_USER_W-1:0]   s_axis_tuser,  // op[1:0]
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dsrb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // stored_value[31:0],
                                                          // read_data[63:32],
                                                          // used_count[74:64],
                                                          // write_pos[84:75]
  output logic [dsrb_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // stored[0]
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dsrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dsrb_pkg::*;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t                    state, state_next;

  logic [MODE_W-1:0]         mode;
  logic [RAT_W-1:0]          ratio;
  logic [SIZE_W-1:0]         ring_size;

  logic [RING_AW-1:0]        write_offset, write_offset_next;
  logic [SIZE_W-1:0]         fill_count, fill_count_next;
  logic [RAT_W-1:0]          group_phase, group_phase_next;
  logic signed [ACC_W-1:0]   accumulator, accumulator_next;

  // divider: quotient shifts in where dividend bits shift out
  logic [ACC_W-1:0]          div_quo, div_quo_next;
  logic [RAT_W-1:0]          div_rem, div_rem_next;
  logic [RAT_W-1:0]          div_den, div_den_next;
  logic [DCNT_W-1:0]         div_cnt, div_cnt_next;
  logic                      div_neg, div_neg_next;

  // read of a position not yet filled answers zero
  logic                      rd_zero, rd_zero_next;

  // output register
  logic                      m_valid, m_valid_next;
  logic                      o_stored, o_stored_next;
  logic [SMP_W-1:0]          o_stored_value, o_stored_value_next;
  logic [SMP_W-1:0]          o_read_data, o_read_data_next;
  logic [SIZE_W-1:0]         o_used_count, o_used_count_next;
  logic [RING_AW-1:0]        o_write_pos, o_write_pos_next;

  // ring ram
  logic [SMP_W-1:0]          ring_mem [RING_DEPTH];
  logic                      wr_en;
  logic [RING_AW-1:0]        wr_addr;
  logic [SMP_W-1:0]          wr_data;
  logic                      rd_en;
  logic [RING_AW-1:0]        rd_addr;
  logic [SMP_W-1:0]          rd_q;

  // --------------------------------------------------------------------------
  // input decode
  // --------------------------------------------------------------------------
  logic                      in_fire;
  op_t                       in_op;
  logic signed [SMP_W-1:0]   in_sample;
  logic [RING_AW-1:0]        in_pos;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_op     = op_t'(s_axis_tuser);
  assign in_sample = s_axis_tdata[SMP_W-1:0];
  assign in_pos    = s_axis_tdata[SMP_W +: RING_AW];

  assign s_axis_tready = (state == ST_IDLE) && !m_valid;
  assign cfg_ready     = 1'b1;

  // --------------------------------------------------------------------------
  // ring pointer arithmetic
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]         eff_size;
  logic [RING_AW-1:0]        put_slot;
  logic [SIZE_W-1:0]         put_inc;
  logic [RING_AW-1:0]        put_offset;
  logic [SIZE_W-1:0]         put_fill;
  logic [SIZE_W-1:0]         fill_lim;
  logic                      get_zero;
  logic [SIZE_W-1:0]         phys_sum;
  logic [RING_AW-1:0]        get_phys;

  always_comb begin
    // zero size acts as one, oversize saturates at the depth
    if (ring_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (ring_size > SIZE_W'(RING_DEPTH)) begin
      eff_size = SIZE_W'(RING_DEPTH);
    end else begin
      eff_size = ring_size;
    end

    // an offset left beyond a shrunken ring writes slot 0
    put_slot   = ({1'b0, write_offset} < eff_size) ? write_offset : '0;
    put_inc    = {1'b0, put_slot} + SIZE_W'(1);
    put_offset = (put_inc >= eff_size) ? '0 : put_inc[RING_AW-1:0];
    put_fill   = (fill_count < eff_size) ? fill_count + SIZE_W'(1) : eff_size;

    // logical to physical position, oldest entry first
    fill_lim = (fill_count < eff_size) ? fill_count : eff_size;
    get_zero = ({1'b0, in_pos} >= fill_lim);
    phys_sum = {1'b0, put_slot} + {1'b0, in_pos};
    if (fill_lim == eff_size) begin
      get_phys = (phys_sum >= eff_size) ? RING_AW'(phys_sum - eff_size)
                                        : phys_sum[RING_AW-1:0];
    end else begin
      get_phys = in_pos;
    end
  end

  // --------------------------------------------------------------------------
  // group reduction for a push
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]   smp_ext;
  logic signed [ACC_W-1:0]   acc_upd;
  logic [RAT_W:0]            grp_count;
  logic [RAT_W-1:0]          grp_n;
  logic                      grp_done;
  logic                      mode_avg;
  logic [ACC_W-1:0]          acc_mag;

  always_comb begin
    smp_ext   = ACC_W'(in_sample);
    grp_n     = (ratio == '0) ? RAT_W'(1) : ratio;
    grp_count = {1'b0, group_phase} + (RAT_W+1)'(1);
    grp_done  = (grp_count >= {1'b0, grp_n});
    mode_avg  = (mode >= MODE_AVG);

    case (mode)
      MODE_MIN: begin
        acc_upd = (group_phase == '0 || smp_ext < accumulator) ? smp_ext : accumulator;
      end
      MODE_MAX: begin
        acc_upd = (group_phase == '0 || smp_ext > accumulator) ? smp_ext : accumulator;
      end
      default: begin
        acc_upd = (group_phase == '0) ? smp_ext : accumulator + smp_ext;
      end
    endcase

    // divider works on magnitudes, sign is restored at the end
    acc_mag = acc_upd[ACC_W-1] ? ACC_W'(-acc_upd) : ACC_W'(acc_upd);
  end

  // --------------------------------------------------------------------------
  // divider step: one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [RAT_W:0]            rem_sh;
  logic                      rem_ge;
  logic [RAT_W:0]            rem_sub;
  logic [ACC_W-1:0]          quo_step;
  logic [ACC_W-1:0]          quo_signed;

  always_comb begin
    rem_sh     = {div_rem, div_quo[ACC_W-1]};
    rem_ge     = (rem_sh >= {1'b0, div_den});
    rem_sub    = rem_ge ? rem_sh - {1'b0, div_den} : rem_sh;
    quo_step   = {div_quo[ACC_W-2:0], rem_ge};
    quo_signed = div_neg ? ACC_W'(-quo_step) : quo_step;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next          = state;
    write_offset_next   = write_offset;
    fill_count_next     = fill_count;
    group_phase_next    = group_phase;
    accumulator_next    = accumulator;
    div_quo_next        = div_quo;
    div_rem_next        = div_rem;
    div_den_next        = div_den;
    div_cnt_next        = div_cnt;
    div_neg_next        = div_neg;
    rd_zero_next        = rd_zero;
    m_valid_next        = m_valid;
    o_stored_next       = o_stored;
    o_stored_value_next = o_stored_value;
    o_read_data_next    = o_read_data;
    o_used_count_next   = o_used_count;
    o_write_pos_next    = o_write_pos;
    wr_en               = 1'b0;
    wr_addr             = put_slot;
    wr_data             = '0;
    rd_en               = 1'b0;
    rd_addr             = get_phys;

    if (m_valid && m_axis_tready) begin
      m_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          // default result: nothing stored, nothing read, pointers unchanged
          o_stored_next       = 1'b0;
          o_stored_value_next = '0;
          o_read_data_next    = '0;
          o_used_count_next   = fill_count;
          o_write_pos_next    = write_offset;
          case (in_op)
            OP_PUSH: begin
              if (mode == MODE_CIRC) begin
                wr_en               = 1'b1;
                wr_data             = in_sample;
                write_offset_next   = put_offset;
                fill_count_next     = put_fill;
                o_stored_next       = 1'b1;
                o_stored_value_next = in_sample;
                o_used_count_next   = put_fill;
                o_write_pos_next    = put_offset;
                m_valid_next        = 1'b1;
              end else if (grp_done && mode_avg) begin
                // group end in average mode: hand off to the divider
                accumulator_next = acc_upd;
                group_phase_next = '0;
                div_quo_next     = acc_mag;
                div_rem_next     = '0;
                div_den_next     = grp_count[RAT_W-1:0];
                div_cnt_next     = DCNT_W'(ACC_W - 1);
                div_neg_next     = acc_upd[ACC_W-1];
                state_next       = ST_DIV;
              end else if (grp_done) begin
                accumulator_next    = acc_upd;
                group_phase_next    = '0;
                wr_en               = 1'b1;
                wr_data             = acc_upd[SMP_W-1:0];
                write_offset_next   = put_offset;
                fill_count_next     = put_fill;
                o_stored_next       = 1'b1;
                o_stored_value_next = acc_upd[SMP_W-1:0];
                o_used_count_next   = put_fill;
                o_write_pos_next    = put_offset;
                m_valid_next        = 1'b1;
              end else begin
                accumulator_next = acc_upd;
                group_phase_next = grp_count[RAT_W-1:0];
                m_valid_next     = 1'b1;
              end
            end
            OP_READ: begin
              rd_en        = 1'b1;
              rd_zero_next = get_zero;
              state_next   = ST_READ;
            end
            OP_CLEAR: begin
              group_phase_next  = '0;
              accumulator_next  = '0;
              write_offset_next = '0;
              fill_count_next   = '0;
              o_used_count_next = '0;
              o_write_pos_next  = '0;
              m_valid_next      = 1'b1;
            end
            default: begin
              m_valid_next = 1'b1;
            end
          endcase
        end
      end

      ST_DIV: begin
        div_quo_next = quo_step;
        div_rem_next = rem_sub[RAT_W-1:0];
        div_cnt_next = div_cnt - DCNT_W'(1);
        if (div_cnt == '0) begin
          // truncated quotient replaces the sum and goes to the ring
          accumulator_next    = quo_signed;
          wr_en               = 1'b1;
          wr_data             = quo_signed[SMP_W-1:0];
          write_offset_next   = put_offset;
          fill_count_next     = put_fill;
          o_stored_next       = 1'b1;
          o_stored_value_next = quo_signed[SMP_W-1:0];
          o_used_count_next   = put_fill;
          o_write_pos_next    = put_offset;
          m_valid_next        = 1'b1;
          state_next          = ST_IDLE;
        end
      end

      ST_READ: begin
        o_read_data_next = rd_zero ? '0 : rd_q;
        m_valid_next     = 1'b1;
        state_next       = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= MODE_CIRC;
      ratio        <= RAT_W'(1);
      ring_size    <= SIZE_W'(RING_DEPTH);
      write_offset <= '0;
      fill_count   <= '0;
      group_phase  <= '0;
      accumulator  <= '0;
      m_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      write_offset <= write_offset_next;
      fill_count   <= fill_count_next;
      group_phase  <= group_phase_next;
      accumulator  <= accumulator_next;
      m_valid      <= m_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:      mode      <= cfg_data[MODE_W-1:0];
          REG_RATIO:     ratio     <= cfg_data[RAT_W-1:0];
          REG_RING_SIZE: ring_size <= cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    div_quo        <= div_quo_next;
    div_rem        <= div_rem_next;
    div_den        <= div_den_next;
    div_cnt        <= div_cnt_next;
    div_neg        <= div_neg_next;
    rd_zero        <= rd_zero_next;
    o_stored       <= o_stored_next;
    o_stored_value <= o_stored_value_next;
    o_read_data    <= o_read_data_next;
    o_used_count   <= o_used_count_next;
    o_write_pos    <= o_write_pos_next;
  end

  // --------------------------------------------------------------------------
  // ring ram: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // output word
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {3'b000, o_write_pos, o_used_count, o_read_data, o_stored_value};
  assign m_axis_tuser  = o_stored;

endmodule
